// ===== hdl/sorted_table_insert_search_core_defines.svh =====
// Assertion macros shared by the sorted table core.
// Depends on nothing; included by the top level.
`ifndef SORTED_TABLE_INSERT_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define STIS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stis: implication check failed");

// Next-cycle implication, disabled in reset.
`define STIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stis: next-cycle check failed");

`endif

// ===== hdl/stis_pkg.sv =====
// Types and constants for the sorted table core.
// Used by the controller, the datapath and the top level.
package stis_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int MAX_RESULTS   = 64;
   localparam int VALUE_W       = 32;
   localparam int INDEX_W       = 6;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_FIND   = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_LISTED    = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef struct packed {
      func_type                    func;
      logic signed [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [INDEX_W-1:0]          index;
      logic signed [VALUE_W-1:0]   entry_value;
      logic                        last;
   } rsp_type;

   typedef enum logic [2:0] {
      POS_HOLD  = 3'd0,
      POS_COUNT = 3'd1,
      POS_ZERO  = 3'd2,
      POS_DEC   = 3'd3,
      POS_INC   = 3'd4
   } pos_op_type;

   typedef enum logic [1:0] {
      RD_POS    = 2'd0,
      RD_POS_M1 = 2'd1,
      RD_POS_M2 = 2'd2,
      RD_POS_P1 = 2'd3
   } rd_sel_type;

   // Controller to datapath.
   typedef struct packed {
      logic        key_load;
      logic        cnt_clear;
      logic        cnt_inc;
      pos_op_type  pos_op;
      rd_sel_type  rd_sel;
      logic        wr_en;
      logic        wr_shift;     // write the entry just read, else the key
      logic        out_load;
      status_type  out_status;
      logic        out_use_pos;
      logic        out_use_data;
      logic        out_last;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic cnt_zero;
      logic full;
      logic pos_zero;
      logic pos_one;
      logic scan_more;
      logic rd_gt;
      logic rd_lt;
      logic rd_eq;
      logic list_last;
   } dp_status_type;

endpackage

// ===== hdl/stis_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module stis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/stis_datapath.sv =====
// Datapath of the sorted table: entry RAM, count, position, key and result register.
// Depends on stis_pkg and stis_ram.
module stis_datapath #(
   parameter int DEPTH = stis_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [stis_pkg::VALUE_W-1:0] req_value,
   input  stis_pkg::dp_cmd_type               cmd,
   output stis_pkg::dp_status_type            status,
   output stis_pkg::rsp_type                  rsp_payload
);
   import stis_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              pos_ff, pos_in;
   logic signed [VALUE_W-1:0]  key_ff;
   rsp_type                    out_ff;

   logic [AW-1:0]              rd_addr;
   logic [VALUE_W-1:0]         rd_data;
   logic [VALUE_W-1:0]         wr_data;
   logic signed [VALUE_W-1:0]  rd_value;
   logic                       list_cap;
   logic [31:0]                list_n;

   stis_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (AW'(pos_ff)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_value = $signed(rd_data);
   assign wr_data  = cmd.wr_shift ? rd_data : key_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_POS:    rd_addr = AW'(pos_ff);
         RD_POS_M1: rd_addr = AW'(pos_ff - CW'(1));
         RD_POS_M2: rd_addr = AW'(pos_ff - CW'(2));
         RD_POS_P1: rd_addr = AW'(pos_ff + CW'(1));
      endcase
   end

   always_comb begin
      unique case (cmd.pos_op)
         POS_HOLD:  pos_in = pos_ff;
         POS_COUNT: pos_in = count_ff;
         POS_ZERO:  pos_in = '0;
         POS_DEC:   pos_in = pos_ff - CW'(1);
         POS_INC:   pos_in = pos_ff + CW'(1);
         default:   pos_in = pos_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clear) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end
   end

   // List stops after MAX_RESULTS entries even when the table holds more.
   assign list_cap = 32'(count_ff) > 32'(MAX_RESULTS);
   assign list_n   = list_cap ? 32'(MAX_RESULTS) : 32'(count_ff);

   assign status.cnt_zero  = (count_ff == '0);
   assign status.full      = (count_ff == CW'(DEPTH));
   assign status.pos_zero  = (pos_ff == '0);
   assign status.pos_one   = (pos_ff == CW'(1));
   assign status.scan_more = ((pos_ff + CW'(1)) < count_ff);
   assign status.rd_gt     = (rd_value > key_ff);
   assign status.rd_lt     = (rd_value < key_ff);
   assign status.rd_eq     = (rd_value == key_ff);
   assign status.list_last = ((32'(pos_ff) + 32'd1) == list_n);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff <= pos_in;
      if (cmd.key_load) begin
         key_ff <= req_value;
      end
      if (cmd.out_load) begin
         out_ff.status      <= cmd.out_status;
         out_ff.index       <= cmd.out_use_pos ? INDEX_W'(pos_ff) : '0;
         out_ff.entry_value <= cmd.out_use_data ? rd_value : '0;
         out_ff.last        <= cmd.out_last;
      end
   end

   assign rsp_payload = out_ff;

endmodule

// ===== hdl/stis_ctrl.sv =====
// Controller of the sorted table: sequences clear, insert, find and list.
// Depends on stis_pkg; drives the datapath through dp_cmd_type.
module stis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  stis_pkg::func_type      req_func,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  stis_pkg::dp_status_type status,
   output stis_pkg::dp_cmd_type    cmd
);
   import stis_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_START,
      S_INS_SHIFT,
      S_FIND_START,
      S_FIND_SCAN,
      S_LIST_RD,
      S_LIST_EMIT,
      S_EMIT
   } state_type;

   state_type   state_ff, state_in;
   status_type  result_ff, result_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;
   logic        out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;

      cmd              = '0;
      cmd.pos_op       = POS_HOLD;
      cmd.rd_sel       = RD_POS;
      cmd.out_status   = ST_DONE;
      cmd.key_load     = accept;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_CLEAR: begin
                     cmd.cnt_clear = 1'b1;
                     result_in     = ST_DONE;
                     state_in      = S_EMIT;
                  end
                  FUNC_INSERT: begin
                     if (status.full) begin
                        result_in = ST_FULL;
                        state_in  = S_EMIT;
                     end else begin
                        cmd.pos_op = POS_COUNT;
                        state_in   = S_INS_START;
                     end
                  end
                  FUNC_FIND: begin
                     cmd.pos_op = POS_ZERO;
                     state_in   = S_FIND_START;
                  end
                  FUNC_LIST: begin
                     cmd.pos_op = POS_ZERO;
                     state_in   = status.cnt_zero ? S_EMIT : S_LIST_RD;
                     result_in  = ST_EMPTY;
                  end
               endcase
            end
         end
         S_INS_START: begin
            if (status.pos_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.cnt_inc = 1'b1;
               result_in   = ST_DONE;
               state_in    = S_EMIT;
            end else begin
               cmd.rd_sel = RD_POS_M1;
               state_in   = S_INS_SHIFT;
            end
         end
         S_INS_SHIFT: begin
            // read data holds the entry just below pos
            cmd.wr_en = 1'b1;
            if (status.rd_gt) begin
               cmd.wr_shift = 1'b1;
               cmd.pos_op   = POS_DEC;
               cmd.rd_sel   = RD_POS_M2;
               if (status.pos_one) begin
                  state_in = S_INS_START;
               end
            end else begin
               cmd.cnt_inc = 1'b1;
               result_in   = ST_DONE;
               state_in    = S_EMIT;
            end
         end
         S_FIND_START: begin
            if (status.cnt_zero) begin
               result_in = ST_NOT_FOUND;
               state_in  = S_EMIT;
            end else begin
               cmd.rd_sel = RD_POS;
               state_in   = S_FIND_SCAN;
            end
         end
         S_FIND_SCAN: begin
            priority if (status.rd_lt && status.scan_more) begin
               cmd.pos_op = POS_INC;
               cmd.rd_sel = RD_POS_P1;
            end else if (status.rd_eq) begin
               result_in = ST_FOUND;
               state_in  = S_EMIT;
            end else begin
               result_in = ST_NOT_FOUND;
               state_in  = S_EMIT;
            end
         end
         S_LIST_RD: begin
            cmd.rd_sel = RD_POS;
            state_in   = S_LIST_EMIT;
         end
         S_LIST_EMIT: begin
            cmd.rd_sel = RD_POS;
            if (out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_status   = ST_LISTED;
               cmd.out_use_pos  = 1'b1;
               cmd.out_use_data = 1'b1;
               cmd.out_last     = status.list_last;
               if (status.list_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.pos_op = POS_INC;
                  state_in   = S_LIST_RD;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_status  = result_ff;
               cmd.out_use_pos = (result_ff == ST_FOUND);
               cmd.out_last    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         result_ff    <= ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         result_ff    <= result_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/sorted_table_insert_search_core.sv =====
// Sorted table of signed words with insert, find, clear and list; one
// transaction is processed at a time. Entries live in a single-port-write,
// registered-read RAM. Clear and an insert into a full table need no RAM
// access; an insert shifts each larger entry up one place in turn, a find
// scans past the smaller entries, and a list reads and emits each entry in
// turn. A result that waits on rsp_ready holds back the next result.
// Results sit in an output register, so a new transaction
// is taken while the last result waits; the entry RAM needs no clearing after
// reset. Depends on stis_pkg, stis_ctrl, stis_datapath, stis_ram and the
// assertion macro header.
`include "sorted_table_insert_search_core_defines.svh"

module sorted_table_insert_search_core #(
   parameter int DEPTH = stis_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stis_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stis_pkg::rsp_type rsp_payload
);
   import stis_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          rsp_not_listed;
   logic          rsp_plain;
   logic          rsp_fields_zero;

   stis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_payload.func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stis_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_value   (req_payload.value),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assign rsp_not_listed  = rsp_valid && (rsp_payload.status != ST_LISTED);
   assign rsp_plain       = rsp_not_listed && (rsp_payload.status != ST_FOUND);
   assign rsp_fields_zero = (rsp_payload.index == '0) && (rsp_payload.entry_value == '0);

   `STIS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `STIS_ASSERT_IMPL(a_no_grow_when_full, clock, reset, cmd.cnt_inc, !status.full)
   `STIS_ASSERT_IMPL(a_single_result_last, clock, reset, rsp_not_listed, rsp_payload.last)
   `STIS_ASSERT_IMPL(a_zero_fields, clock, reset, rsp_plain, rsp_fields_zero)

endmodule
